>>> rtl/scfifo_pkg.sv
// Shared types and constants for the scancode FIFO with modifier tracking.
// No dependencies; used by the controller, the datapath and the top level.
package scfifo_pkg;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_PUSH = 2'd1;
	localparam logic [1:0] CMD_POP  = 2'd2;

	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;

	typedef struct packed {
		logic do_tick;
		logic do_push;
		logic do_result;
		logic do_pop_rd;
		logic do_pop_fin;
		logic out_take;
	} ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic out_valid;
	} sts_t;

endpackage

>>> rtl/scfifo_ctrl.sv
// Controller for the scancode FIFO: handshake and sequencing of each event.
// Depends on scfifo_pkg; drives command signals into scfifo_dp.
module scfifo_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         command,
	input  logic               out_ready,
	input  scfifo_pkg::sts_t   sts,
	output logic               in_ready,
	output scfifo_pkg::ctl_t   ctl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign in_ready = (state_q == ST_IDLE) && (!sts.out_valid || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		ctl            = '0;
		state_d        = state_q;
		ctl.out_take   = sts.out_valid && out_ready;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (command)
						scfifo_pkg::CMD_TICK: begin
							ctl.do_tick   = 1'b1;
							ctl.do_result = 1'b1;
						end
						scfifo_pkg::CMD_PUSH: begin
							ctl.do_push   = 1'b1;
							ctl.do_result = 1'b1;
						end
						scfifo_pkg::CMD_POP: begin
							if (sts.empty) begin
								ctl.do_result = 1'b1;
							end else begin
								ctl.do_pop_rd = 1'b1;
								state_d       = ST_POP;
							end
						end
						default: begin
							ctl.do_result = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				ctl.do_pop_fin = 1'b1;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/scfifo_dp.sv
// Datapath for the scancode FIFO: code memory, ring indices, modifier flags,
// tick counter and the output register. Depends on scfifo_pkg.
module scfifo_dp #(
	parameter int DEPTH = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scfifo_pkg::ctl_t   ctl,
	input  logic [7:0]         scancode,
	output scfifo_pkg::sts_t   sts,
	output logic               code_valid,
	output logic [7:0]         popped_code,
	output logic               shift_held,
	output logic               caps_on,
	output logic [31:0]        tick_total,
	output logic               dropped
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] wr_idx_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] wr_next;
	logic [AW-1:0] rd_next;
	logic          shift_q;
	logic          caps_q;
	logic [31:0]   tick_q;
	logic [31:0]   tick_d;
	logic          shift_d;
	logic          caps_d;
	logic          out_valid_q;
	logic          code_valid_q;
	logic [7:0]    popped_code_q;
	logic          dropped_q;
	logic          push_ok;

	assign wr_next   = (wr_idx_q == LAST) ? '0 : wr_idx_q + AW'(1);
	assign rd_next   = (rd_idx_q == LAST) ? '0 : rd_idx_q + AW'(1);
	assign sts.empty = (wr_idx_q == rd_idx_q);
	assign sts.full  = (wr_next == rd_idx_q);
	assign sts.out_valid = out_valid_q;
	assign push_ok   = ctl.do_push && !sts.full;
	assign tick_d    = ctl.do_tick ? tick_q + 32'd1 : tick_q;

	always_comb begin
		shift_d = shift_q;
		caps_d  = caps_q;
		if (ctl.do_pop_fin) begin
			if (rd_data_q == scfifo_pkg::SC_LSHIFT_MAKE ||
			    rd_data_q == scfifo_pkg::SC_RSHIFT_MAKE) begin
				shift_d = 1'b1;
			end else if (rd_data_q == scfifo_pkg::SC_LSHIFT_BREAK ||
			             rd_data_q == scfifo_pkg::SC_RSHIFT_BREAK) begin
				shift_d = 1'b0;
			end else if (rd_data_q == scfifo_pkg::SC_CAPS_MAKE) begin
				caps_d = !caps_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_idx_q] <= scancode;
		end
		if (ctl.do_pop_rd) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			shift_q     <= 1'b0;
			caps_q      <= 1'b0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_ok) begin
				wr_idx_q <= wr_next;
			end
			if (ctl.do_pop_rd) begin
				rd_idx_q <= rd_next;
			end
			shift_q <= shift_d;
			caps_q  <= caps_d;
			tick_q  <= tick_d;
			if (ctl.do_result || ctl.do_pop_fin) begin
				out_valid_q <= 1'b1;
			end else if (ctl.out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result register; it holds while the consumer stalls.
	always_ff @(posedge clk) begin
		if (ctl.do_result || ctl.do_pop_fin) begin
			code_valid_q  <= ctl.do_pop_fin;
			popped_code_q <= ctl.do_pop_fin ? rd_data_q : 8'd0;
			dropped_q     <= ctl.do_push && sts.full;
			shift_held    <= shift_d;
			caps_on       <= caps_d;
			tick_total    <= tick_d;
		end
	end

	assign code_valid  = code_valid_q;
	assign popped_code = popped_code_q;
	assign dropped     = dropped_q;

endmodule

>>> rtl/scancode_fifo_with_modifiers.sv
// Top level of the scancode FIFO with Shift and Caps Lock tracking.
// Depends on scfifo_pkg, scfifo_ctrl and scfifo_dp.
//
// Events arrive on a valid/ready input channel and each produces exactly one
// result on a valid/ready output channel, held in an output register. A pop
// that returns a code reads the registered code memory port first and loads
// the result from the pop state; every other event loads it on acceptance.
// A new event is taken while the previous result still waits, as long as no
// pop is in flight and the result register is being drained or is free. The
// ring holds DEPTH-1 codes; memory contents are not cleared at reset, and no
// clearing pass is needed because only written slots are ever read.
module scancode_fifo_with_modifiers #(
	parameter int DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  scancode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        code_valid,
	output logic [7:0]  popped_code,
	output logic        shift_held,
	output logic        caps_on,
	output logic [31:0] tick_total,
	output logic        dropped
);

	scfifo_pkg::ctl_t ctl;
	scfifo_pkg::sts_t sts;

	scfifo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.command   (command),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.ctl       (ctl)
	);

	scfifo_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.scancode    (scancode),
		.sts         (sts),
		.code_valid  (code_valid),
		.popped_code (popped_code),
		.shift_held  (shift_held),
		.caps_on     (caps_on),
		.tick_total  (tick_total),
		.dropped     (dropped)
	);

	assign out_valid = sts.out_valid;

	a_not_full_and_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.full && sts.empty))
		else $error("ring reports full and empty at once");

	a_pop_blocks_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == scfifo_pkg::CMD_POP && !sts.empty)
		|=> (!in_ready && out_valid == $past(out_valid && !out_ready)))
		else $error("input taken while a pop is in flight");

	a_drop_not_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(dropped && code_valid))
		else $error("result both dropped and popped");

	a_ready_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while result register is stalled");

endmodule

>>> verif/scancode_fifo_with_modifiers_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for scancode_fifo_with_modifiers: directed and random event traffic.
// Results are checked against an in-bench model of the ring, modifiers and tick count.
// Depends on scfifo_pkg and the scancode_fifo_with_modifiers RTL.
module scancode_fifo_with_modifiers_tb;

	localparam int DEPTH = 512;
	localparam int ITEMS_TARGET = 1750;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic        code_valid;
		logic [7:0]  popped_code;
		logic        shift_held;
		logic        caps_on;
		logic [31:0] tick_total;
		logic        dropped;
	} report_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] sc;
		logic       typed;
		report_t    want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [7:0]  scancode;
	logic        out_valid;
	logic        out_ready;
	logic        code_valid;
	logic [7:0]  popped_code;
	logic        shift_held;
	logic        caps_on;
	logic [31:0] tick_total;
	logic        dropped;

	logic [7:0]  ring_store [DEPTH];
	int          wr_ptr;
	int          rd_ptr;
	logic        shift_q;
	logic        caps_q;
	logic [31:0] ticks_q;

	report_t     pending_reports [$];
	row_t        plan [$];
	int          mismatches;
	int          cycles;
	int          events_sent;
	int          codes_popped;
	int          arrivals_dropped;
	int          peak_fill;
	bit          steady_feed;
	bit          steady_drain;

	scancode_fifo_with_modifiers #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.scancode(scancode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_valid(code_valid),
		.popped_code(popped_code),
		.shift_held(shift_held),
		.caps_on(caps_on),
		.tick_total(tick_total),
		.dropped(dropped)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int ring_fill();
		return (wr_ptr - rd_ptr + DEPTH) % DEPTH;
	endfunction

	function automatic report_t ring_step(logic [1:0] cmd, logic [7:0] sc);
		report_t r;
		logic [7:0] head;
		r = '0;
		case (cmd)
			scfifo_pkg::CMD_TICK: ticks_q = ticks_q + 32'd1;
			scfifo_pkg::CMD_PUSH: begin
				if ((wr_ptr + 1) % DEPTH != rd_ptr) begin
					ring_store[wr_ptr] = sc;
					wr_ptr = (wr_ptr + 1) % DEPTH;
				end else begin
					r.dropped = 1'b1;
				end
			end
			scfifo_pkg::CMD_POP: begin
				if (wr_ptr != rd_ptr) begin
					head = ring_store[rd_ptr];
					rd_ptr = (rd_ptr + 1) % DEPTH;
					if (head == scfifo_pkg::SC_LSHIFT_MAKE ||
					    head == scfifo_pkg::SC_RSHIFT_MAKE)
						shift_q = 1'b1;
					else if (head == scfifo_pkg::SC_LSHIFT_BREAK ||
					         head == scfifo_pkg::SC_RSHIFT_BREAK)
						shift_q = 1'b0;
					else if (head == scfifo_pkg::SC_CAPS_MAKE)
						caps_q = ~caps_q;
					r.code_valid = 1'b1;
					r.popped_code = head;
				end
			end
			default: ;
		endcase
		r.shift_held = shift_q;
		r.caps_on = caps_q;
		r.tick_total = ticks_q;
		return r;
	endfunction

	function automatic report_t make_report(logic v, logic [7:0] code, logic sh, logic cp,
			logic [31:0] ticks, logic drp);
		report_t r;
		r.code_valid = v;
		r.popped_code = code;
		r.shift_held = sh;
		r.caps_on = cp;
		r.tick_total = ticks;
		r.dropped = drp;
		return r;
	endfunction

	function automatic row_t typed_row(logic [1:0] cmd, logic [7:0] sc, report_t want);
		row_t r;
		r.cmd = cmd;
		r.sc = sc;
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic row_t open_row(logic [1:0] cmd, logic [7:0] sc);
		row_t r;
		r.cmd = cmd;
		r.sc = sc;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	task automatic send_event(logic [1:0] cmd, logic [7:0] sc, logic typed, report_t want);
		int gap;
		report_t predicted;
		gap = steady_feed ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		scancode <= sc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = ring_step(cmd, sc);
		pending_reports.push_back(typed ? want : predicted);
		events_sent++;
		if (predicted.dropped) arrivals_dropped++;
		if (predicted.code_valid) codes_popped++;
		if (ring_fill() > peak_fill) peak_fill = ring_fill();
		if (events_sent % 64 == 0) begin
			steady_feed = ($urandom_range(0, 3) == 0);
			steady_drain = ($urandom_range(0, 3) == 0);
		end
	endtask

	task automatic send_mix(int push_pct, int pop_pct);
		int r;
		logic [1:0] cmd;
		logic [7:0] sc;
		r = $urandom_range(0, 99);
		if (r < push_pct) cmd = scfifo_pkg::CMD_PUSH;
		else if (r < push_pct + pop_pct) cmd = scfifo_pkg::CMD_POP;
		else if (r < 97) cmd = scfifo_pkg::CMD_TICK;
		else cmd = CMD_UNUSED;
		case ($urandom_range(0, 7))
			0: sc = scfifo_pkg::SC_LSHIFT_MAKE;
			1: sc = scfifo_pkg::SC_RSHIFT_MAKE;
			2: sc = scfifo_pkg::SC_LSHIFT_BREAK;
			3: sc = scfifo_pkg::SC_RSHIFT_BREAK;
			4: sc = scfifo_pkg::SC_CAPS_MAKE;
			default: sc = 8'($urandom);
		endcase
		send_event(cmd, sc, 1'b0, '0);
	endtask

	task automatic wait_idle();
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	// receiver: random stall before each result, none during steady stretches
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady_drain ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		report_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result transfer");
				mismatches++;
			end else begin
				exp_r = pending_reports.pop_front();
				if (code_valid !== exp_r.code_valid) begin
					$error("code_valid expected %0h got %0h", exp_r.code_valid, code_valid);
					mismatches++;
				end
				if (popped_code !== exp_r.popped_code) begin
					$error("popped_code expected %0h got %0h", exp_r.popped_code, popped_code);
					mismatches++;
				end
				if (shift_held !== exp_r.shift_held) begin
					$error("shift_held expected %0h got %0h", exp_r.shift_held, shift_held);
					mismatches++;
				end
				if (caps_on !== exp_r.caps_on) begin
					$error("caps_on expected %0h got %0h", exp_r.caps_on, caps_on);
					mismatches++;
				end
				if (tick_total !== exp_r.tick_total) begin
					$error("tick_total expected %0h got %0h", exp_r.tick_total, tick_total);
					mismatches++;
				end
				if (dropped !== exp_r.dropped) begin
					$error("dropped expected %0h got %0h", exp_r.dropped, dropped);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = scfifo_pkg::CMD_TICK;
		scancode = 8'h00;
		events_sent = 0;
		codes_popped = 0;
		arrivals_dropped = 0;
		peak_fill = 0;
		steady_feed = 1'b0;
		steady_drain = 1'b0;
		wr_ptr = 0;
		rd_ptr = 0;
		shift_q = 1'b0;
		caps_q = 1'b0;
		ticks_q = 32'd0;

		// reset state, empty pop, unused command, byte extremes
		plan.push_back(typed_row(scfifo_pkg::CMD_POP, 8'h00,
			make_report(1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0)));
		plan.push_back(typed_row(CMD_UNUSED, 8'hFF,
			make_report(1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0)));
		plan.push_back(typed_row(scfifo_pkg::CMD_TICK, 8'h00,
			make_report(1'b0, 8'h00, 1'b0, 1'b0, 32'd1, 1'b0)));
		plan.push_back(typed_row(scfifo_pkg::CMD_PUSH, 8'h00,
			make_report(1'b0, 8'h00, 1'b0, 1'b0, 32'd1, 1'b0)));
		plan.push_back(typed_row(scfifo_pkg::CMD_PUSH, 8'hFF,
			make_report(1'b0, 8'h00, 1'b0, 1'b0, 32'd1, 1'b0)));
		plan.push_back(typed_row(scfifo_pkg::CMD_POP, 8'h00,
			make_report(1'b1, 8'h00, 1'b0, 1'b0, 32'd1, 1'b0)));
		plan.push_back(typed_row(scfifo_pkg::CMD_POP, 8'h55,
			make_report(1'b1, 8'hFF, 1'b0, 1'b0, 32'd1, 1'b0)));
		plan.push_back(typed_row(scfifo_pkg::CMD_POP, 8'hAA,
			make_report(1'b0, 8'h00, 1'b0, 1'b0, 32'd1, 1'b0)));
		// modifiers: both shifts make and break, caps toggled twice
		plan.push_back(open_row(scfifo_pkg::CMD_PUSH, scfifo_pkg::SC_LSHIFT_MAKE));
		plan.push_back(open_row(scfifo_pkg::CMD_POP, 8'h00));
		plan.push_back(open_row(scfifo_pkg::CMD_PUSH, scfifo_pkg::SC_LSHIFT_BREAK));
		plan.push_back(open_row(scfifo_pkg::CMD_POP, 8'h00));
		plan.push_back(open_row(scfifo_pkg::CMD_PUSH, scfifo_pkg::SC_RSHIFT_MAKE));
		plan.push_back(open_row(scfifo_pkg::CMD_PUSH, scfifo_pkg::SC_CAPS_MAKE));
		plan.push_back(open_row(scfifo_pkg::CMD_POP, 8'h00));
		plan.push_back(open_row(scfifo_pkg::CMD_POP, 8'h00));
		plan.push_back(open_row(scfifo_pkg::CMD_PUSH, scfifo_pkg::SC_RSHIFT_BREAK));
		plan.push_back(open_row(scfifo_pkg::CMD_PUSH, scfifo_pkg::SC_CAPS_MAKE));
		plan.push_back(open_row(scfifo_pkg::CMD_PUSH, 8'h55));
		plan.push_back(open_row(scfifo_pkg::CMD_POP, 8'h00));
		plan.push_back(open_row(scfifo_pkg::CMD_POP, 8'h00));
		plan.push_back(open_row(scfifo_pkg::CMD_POP, 8'h00));
		plan.push_back(open_row(CMD_UNUSED, 8'h00));
		plan.push_back(open_row(scfifo_pkg::CMD_TICK, 8'hFF));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_event(plan[i].cmd, plan[i].sc, plan[i].typed, plan[i].want);

		// hold the sender until every result is back
		in_valid <= 1'b0;
		wait_idle();

		repeat (300) send_mix(45, 40);

		// fill the ring, then work the full boundary with drops
		while (ring_fill() < DEPTH - 1) send_mix(85, 7);
		repeat (60) send_mix(75, 20);

		in_valid <= 1'b0;
		wait_idle();

		// drain to empty, then pop past it
		while (ring_fill() != 0) send_mix(5, 88);
		repeat (10) send_mix(0, 95);

		while (events_sent < ITEMS_TARGET) send_mix(40, 40);
		in_valid <= 1'b0;

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d events: %0d codes popped, %0d arrivals dropped, peak fill %0d of %0d.",
			events_sent, codes_popped, arrivals_dropped, peak_fill, DEPTH - 1);
		$display("Final ticks %0d, shift %0b, caps %0b, mismatches %0d.",
			ticks_q, shift_q, caps_q, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
